@@ rtl/uqpd_pkg.sv @@
// ============================================================================
// uqpd_pkg
// Shared constants and helpers for the URL query percent decoder.
// ============================================================================
`default_nettype none

package uqpd_pkg;

    localparam int unsigned CfgAddrW = 3;
    localparam int unsigned CfgDataW = 8;

    localparam logic [CfgAddrW-1:0] REG_QUERY_MODE     = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_PLUS_CHAR      = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_STRICT_INVALID = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_PAIR_SEP_CODE  = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_KV_SEP_CODE    = 3'd4;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [7:0] RST_PLUS_CHAR     = 8'd32;
    localparam logic [7:0] RST_PAIR_SEP_CODE = 8'd38;
    localparam logic [7:0] RST_KV_SEP_CODE   = 8'd61;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

@@ rtl/url_query_percent_decoder.sv @@
// ============================================================================
// url_query_percent_decoder
// Streaming percent decoder with plain and query key/value modes.
// ============================================================================
// Each input beat is decoded in the cycle it is accepted and its results (one
// to three bytes, or none) are loaded into an output register that emits one
// beat per cycle while m_ready is high. A byte giving at most one result
// flows at one byte per clock while m_ready is high; a byte giving more results
// holds the output register, and the next input beat is taken in the cycle that
// the last of them leaves. Escape digits and dropped bytes load no output beat.
`default_nettype none

module url_query_percent_decoder (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            cfg_we,
    input  wire logic [uqpd_pkg::CfgAddrW-1:0]   cfg_addr,
    input  wire logic [uqpd_pkg::CfgDataW-1:0]   cfg_wdata,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [7:0]                      s_in_byte,
    input  wire logic                            s_end_of_input,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [7:0]                           m_out_byte,
    output logic                                 m_error,
    output logic                                 m_last_of_run,
    output logic                                 m_end_of_string
);

    typedef enum logic [1:0] {
        PH_NONE,
        PH_PCT,
        PH_DIGIT
    } phase_t;

    // configuration
    logic       query_mode_reg;
    logic [7:0] plus_char_reg;
    logic       strict_invalid_reg;
    logic [7:0] pair_sep_code_reg;
    logic [7:0] kv_sep_code_reg;

    // string state
    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic       in_value_reg, in_value_next;
    logic       drop_reg, drop_next;

    // result bundle
    logic [1:0] cnt_reg, cnt_next;
    logic [7:0] b0_reg, b1_reg, b2_reg;
    logic [7:0] b0_next, b1_next, b2_next;
    logic       err_reg, err_next;
    logic       eos_reg, eos_next;

    logic       s_fire, m_fire;
    logic [7:0] plusmap, sep_code, pm_in, pm_held;
    logic       strict, sep, give_err;
    uqpd_pkg::hex_t hx_held, hx_in;

    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;
    assign m_valid = (cnt_reg != 2'd0);
    assign s_ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);

    assign m_out_byte      = b0_reg;
    assign m_error         = err_reg;
    assign m_last_of_run   = (cnt_reg == 2'd1);
    assign m_end_of_string = eos_reg && (cnt_reg == 2'd1);

    always_comb begin
        plusmap  = query_mode_reg ? (in_value_reg ? uqpd_pkg::CH_SPACE : uqpd_pkg::CH_PLUS)
                                  : plus_char_reg;
        strict   = !query_mode_reg && strict_invalid_reg;
        sep      = query_mode_reg && ((s_in_byte == uqpd_pkg::CH_AMP) ||
                   ((s_in_byte == uqpd_pkg::CH_EQUALS) && !in_value_reg));
        sep_code = (s_in_byte == uqpd_pkg::CH_AMP) ? pair_sep_code_reg : kv_sep_code_reg;
        pm_in    = (s_in_byte == uqpd_pkg::CH_PLUS) ? plusmap : s_in_byte;
        pm_held  = (held_reg == uqpd_pkg::CH_PLUS) ? plusmap : held_reg;
        hx_held  = uqpd_pkg::hex_decode(held_reg);
        hx_in    = uqpd_pkg::hex_decode(s_in_byte);
    end

    always_comb begin
        phase_next    = phase_reg;
        held_next     = held_reg;
        in_value_next = in_value_reg;
        drop_next     = drop_reg;
        give_err      = 1'b0;

        // drain the output register one beat at a time
        cnt_next = cnt_reg;
        b0_next  = b1_reg;
        b1_next  = b2_reg;
        b2_next  = b2_reg;
        err_next = err_reg;
        eos_next = eos_reg;
        if (m_fire) begin
            cnt_next = cnt_reg - 2'd1;
        end else begin
            b0_next = b0_reg;
            b1_next = b1_reg;
        end

        if (s_fire) begin
            cnt_next = 2'd0;
            b0_next  = 8'd0;
            b1_next  = 8'd0;
            b2_next  = 8'd0;
            err_next = 1'b0;
            eos_next = s_end_of_input;

            if (drop_reg) begin
                // hold off until the end of the rejected string
            end else if (sep) begin
                phase_next    = PH_NONE;
                held_next     = 8'd0;
                in_value_next = (s_in_byte != uqpd_pkg::CH_AMP);
                unique case (phase_reg)
                    PH_PCT: begin
                        cnt_next = 2'd2;
                        b0_next  = uqpd_pkg::CH_PERCENT;
                        b1_next  = sep_code;
                    end
                    PH_DIGIT: begin
                        cnt_next = 2'd3;
                        b0_next  = uqpd_pkg::CH_PERCENT;
                        b1_next  = pm_held;
                        b2_next  = sep_code;
                    end
                    default: begin
                        cnt_next = 2'd1;
                        b0_next  = sep_code;
                    end
                endcase
            end else begin
                unique case (phase_reg)
                    PH_PCT: begin
                        if (s_end_of_input) begin
                            if (strict) begin
                                give_err = 1'b1;
                            end else begin
                                cnt_next   = 2'd2;
                                b0_next    = uqpd_pkg::CH_PERCENT;
                                b1_next    = pm_in;
                                phase_next = PH_NONE;
                            end
                        end else begin
                            held_next  = s_in_byte;
                            phase_next = PH_DIGIT;
                        end
                    end
                    PH_DIGIT: begin
                        phase_next = PH_NONE;
                        held_next  = 8'd0;
                        if (hx_held.valid && hx_in.valid) begin
                            cnt_next = 2'd1;
                            b0_next  = {hx_held.value, hx_in.value};
                        end else if (strict) begin
                            give_err = 1'b1;
                        end else begin
                            cnt_next = 2'd3;
                            b0_next  = uqpd_pkg::CH_PERCENT;
                            b1_next  = held_reg;
                            b2_next  = s_in_byte;
                        end
                    end
                    default: begin
                        if (s_in_byte == uqpd_pkg::CH_PERCENT) begin
                            if (!s_end_of_input) begin
                                phase_next = PH_PCT;
                            end else if (strict) begin
                                give_err = 1'b1;
                            end else begin
                                cnt_next = 2'd1;
                                b0_next  = uqpd_pkg::CH_PERCENT;
                            end
                        end else begin
                            cnt_next = 2'd1;
                            b0_next  = pm_in;
                        end
                    end
                endcase
            end

            if (give_err) begin
                cnt_next = 2'd1;
                b0_next  = 8'd0;
                err_next = 1'b1;
                eos_next = 1'b1;
            end

            if (give_err || s_end_of_input) begin
                phase_next    = PH_NONE;
                held_next     = 8'd0;
                in_value_next = 1'b0;
                drop_next     = give_err && !s_end_of_input;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_mode_reg     <= 1'b0;
            plus_char_reg      <= uqpd_pkg::RST_PLUS_CHAR;
            strict_invalid_reg <= 1'b0;
            pair_sep_code_reg  <= uqpd_pkg::RST_PAIR_SEP_CODE;
            kv_sep_code_reg    <= uqpd_pkg::RST_KV_SEP_CODE;
            phase_reg          <= PH_NONE;
            held_reg           <= 8'd0;
            in_value_reg       <= 1'b0;
            drop_reg           <= 1'b0;
            cnt_reg            <= 2'd0;
            err_reg            <= 1'b0;
            eos_reg            <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    uqpd_pkg::REG_QUERY_MODE:     query_mode_reg     <= cfg_wdata[0];
                    uqpd_pkg::REG_PLUS_CHAR:      plus_char_reg      <= cfg_wdata;
                    uqpd_pkg::REG_STRICT_INVALID: strict_invalid_reg <= cfg_wdata[0];
                    uqpd_pkg::REG_PAIR_SEP_CODE:  pair_sep_code_reg  <= cfg_wdata;
                    uqpd_pkg::REG_KV_SEP_CODE:    kv_sep_code_reg    <= cfg_wdata;
                    default: ;
                endcase
            end
            phase_reg    <= phase_next;
            held_reg     <= held_next;
            in_value_reg <= in_value_next;
            drop_reg     <= drop_next;
            cnt_reg      <= cnt_next;
            err_reg      <= err_next;
            eos_reg      <= eos_next;
        end
    end

    always_ff @(posedge aclk) begin
        b0_reg <= b0_next;
        b1_reg <= b1_next;
        b2_reg <= b2_next;
    end

    a_err_beat_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error) |-> (m_out_byte == 8'd0 && m_last_of_run && m_end_of_string))
        else $error("error beat is not a lone zero end-of-string beat");

    a_drop_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && drop_reg) |=> !m_valid)
        else $error("dropped byte produced a result");

    a_err_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error) |-> (phase_reg == PH_NONE && !in_value_reg))
        else $error("string state not cleared after error");

endmodule

`default_nettype wire

@@ dv/url_query_percent_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// url_query_percent_decoder_tb
// Self-checking bench for the percent decoder. A directed set of strings
// covers escapes, '+' mapping, strict errors and query separators. Random
// strings follow under changing register settings. A scoreboard predicts
// every output beat from each accepted input beat and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module url_query_percent_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uqpd_pkg::*;

    localparam int NUM_PHASES  = 8;
    localparam int PHASE_BYTES = 52;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       err;
        logic       last;
        logic       eos;
    } beat_t;

    class decode_board;
        logic       qmode;
        logic [7:0] plus_cfg;
        logic       strict_cfg;
        logic [7:0] amp_code;
        logic [7:0] eq_code;
        logic [1:0] esc;
        logic [7:0] held;
        logic       in_val;
        logic       dropping;
        beat_t      pending[$];
        beat_t      run[3];
        int         nrun;
        int         fails;

        function new();
            qmode      = 1'b0;
            plus_cfg   = RST_PLUS_CHAR;
            strict_cfg = 1'b0;
            amp_code   = RST_PAIR_SEP_CODE;
            eq_code    = RST_KV_SEP_CODE;
            fails      = 0;
            clear_str();
        endfunction

        function void clear_str();
            esc      = 2'd0;
            held     = 8'h00;
            in_val   = 1'b0;
            dropping = 1'b0;
        endfunction

        function void write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
            case (idx)
                REG_QUERY_MODE:     qmode      = val[0];
                REG_PLUS_CHAR:      plus_cfg   = val;
                REG_STRICT_INVALID: strict_cfg = val[0];
                REG_PAIR_SEP_CODE:  amp_code   = val;
                REG_KV_SEP_CODE:    eq_code    = val;
                default: ;
            endcase
        endfunction

        function int hexv(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c) - int'("0");
            if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
            if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
            return -1;
        endfunction

        function void emit(logic [7:0] d);
            run[nrun] = '{d, 1'b0, 1'b0, 1'b0};
            nrun++;
        endfunction

        function void reject(logic eoi);
            pending.push_back('{8'h00, 1'b1, 1'b1, 1'b1});
            clear_str();
            dropping = !eoi;
        endfunction

        function void note_byte(logic [7:0] b, logic eoi);
            logic [7:0] pm;
            logic       strict;
            logic       sep;
            int         hi;
            int         lo;
            nrun = 0;
            if (dropping) begin
                if (eoi) clear_str();
                return;
            end
            if (qmode) begin
                pm     = in_val ? CH_SPACE : CH_PLUS;
                strict = 1'b0;
                sep    = (b == CH_AMP) || (b == CH_EQUALS && !in_val);
            end else begin
                pm     = plus_cfg;
                strict = strict_cfg;
                sep    = 1'b0;
            end
            if (sep) begin
                if (esc != 2'd0) emit(CH_PERCENT);
                if (esc == 2'd2) emit(held == CH_PLUS ? pm : held);
                esc  = 2'd0;
                held = 8'h00;
                if (b == CH_AMP) begin
                    emit(amp_code);
                    in_val = 1'b0;
                end else begin
                    emit(eq_code);
                    in_val = 1'b1;
                end
            end else if (esc == 2'd0) begin
                if (b == CH_PERCENT) begin
                    if (eoi) begin
                        if (strict) begin
                            reject(eoi);
                            return;
                        end
                        emit(CH_PERCENT);
                    end else begin
                        esc = 2'd1;
                    end
                end else begin
                    emit(b == CH_PLUS ? pm : b);
                end
            end else if (esc == 2'd1) begin
                if (eoi) begin
                    if (strict) begin
                        reject(eoi);
                        return;
                    end
                    emit(CH_PERCENT);
                    emit(b == CH_PLUS ? pm : b);
                    esc = 2'd0;
                end else begin
                    held = b;
                    esc  = 2'd2;
                end
            end else begin
                hi  = hexv(held);
                lo  = hexv(b);
                esc = 2'd0;
                if (hi >= 0 && lo >= 0) begin
                    emit({hi[3:0], lo[3:0]});
                end else begin
                    if (strict) begin
                        reject(eoi);
                        return;
                    end
                    emit(CH_PERCENT);
                    emit(held);
                    emit(b);
                end
                held = 8'h00;
            end
            for (int k = 0; k < nrun; k++) begin
                if (k == nrun - 1) begin
                    run[k].last = 1'b1;
                    run[k].eos  = eoi;
                end
                pending.push_back(run[k]);
            end
            if (eoi) clear_str();
        endfunction

        function void check_beat(beat_t got);
            beat_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual data=%02h err=%0b last=%0b eos=%0b",
                         $time, got.data, got.err, got.last, got.eos);
                fails++;
                return;
            end
            want = pending.pop_front();
            if (got.data !== want.data) begin
                $display("%0t: out_byte expected %02h actual %02h", $time, want.data, got.data);
                fails++;
            end
            if (got.err !== want.err) begin
                $display("%0t: error expected %0b actual %0b", $time, want.err, got.err);
                fails++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last_of_run expected %0b actual %0b", $time, want.last, got.last);
                fails++;
            end
            if (got.eos !== want.eos) begin
                $display("%0t: end_of_string expected %0b actual %0b", $time, want.eos, got.eos);
                fails++;
            end
        endfunction
    endclass

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                cfg_we         = 1'b0;
    logic [CfgAddrW-1:0] cfg_addr       = '0;
    logic [CfgDataW-1:0] cfg_wdata      = '0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [7:0]          s_in_byte      = 8'h00;
    logic                s_end_of_input = 1'b0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [7:0]          m_out_byte;
    logic                m_error;
    logic                m_last_of_run;
    logic                m_end_of_string;

    decode_board board;
    bit          quiet;
    bit          hold_off_req;

    url_query_percent_decoder u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_end_of_input  (s_end_of_input),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_error         (m_error),
        .m_last_of_run   (m_last_of_run),
        .m_end_of_string (m_end_of_string)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_byte(s_in_byte, s_end_of_input);
            if (m_valid && m_ready)
                board.check_beat('{m_out_byte, m_error, m_last_of_run, m_end_of_string});
        end
    end

    initial begin : sink_proc
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 17);
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge aclk);
        end
    end

    task automatic send_byte(logic [7:0] b, logic eoi);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_in_byte      <= b;
        s_end_of_input <= eoi;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task automatic send_str(string s, bit end_last);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], end_last && (i == s.len() - 1));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic cfg_beat(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        board.write_reg(idx, val);
    endtask

    task automatic apply_cfg(logic qm, logic [7:0] pc, logic si, logic [7:0] ps,
                             logic [7:0] kv);
        cfg_beat(REG_QUERY_MODE, {7'd0, qm});
        cfg_beat(REG_PLUS_CHAR, pc);
        cfg_beat(REG_STRICT_INVALID, {7'd0, si});
        cfg_beat(REG_PAIR_SEP_CODE, ps);
        cfg_beat(REG_KV_SEP_CODE, kv);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] pick_code(int p);
        case (p % 4)
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_string(output int nbytes);
        logic [7:0] txt[$];
        int         len;
        int         pick;
        len = $urandom_range(1, 12);
        while (txt.size() < len) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                txt.push_back(CH_PERCENT);
                txt.push_back(hex_char());
                txt.push_back(hex_char());
            end else if (pick < 60) begin
                txt.push_back(pick[0] ? 8'($urandom_range(8'h61, 8'h7A)) : hex_char());
            end else if (pick < 70) begin
                txt.push_back(CH_PLUS);
            end else if (pick < 80) begin
                txt.push_back(pick[0] ? CH_AMP : CH_EQUALS);
            end else if (pick < 88) begin
                txt.push_back(CH_PERCENT);
                txt.push_back(8'($urandom_range(0, 255)));
                if (pick[0]) txt.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 95) begin
                txt.push_back(8'($urandom_range(0, 255)));
            end else begin
                txt.push_back(CH_PERCENT);
            end
        end
        foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
        nbytes = txt.size();
    endtask

    initial begin : stim_proc
        int sent;
        int n;
        board = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_str("+%41%4g", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_str("%", 1'b1);
        send_str("%+", 1'b1);
        wait_idle();

        apply_cfg(1'b0, 8'hFF, 1'b1, RST_PAIR_SEP_CODE, RST_KV_SEP_CODE);
        send_str("%g1ab", 1'b1);
        send_str("%", 1'b1);
        wait_idle();

        apply_cfg(1'b1, 8'h00, 1'b1, 8'h00, 8'hFF);
        send_str("+=+=%4&%=", 1'b1);
        send_str("a=%4", 1'b0);
        wait_idle();

        apply_cfg(1'b0, 8'h7E, 1'b0, 8'hFF, 8'h00);
        send_str("1", 1'b1);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            quiet = (p >= NUM_PHASES - 2);
            apply_cfg((p < 2) ? p[0] : 1'($urandom_range(0, 1)), pick_code(p),
                      (p == 2 || p == 4) ? 1'b1 : 1'($urandom_range(0, 1)),
                      pick_code(p + 1), pick_code(p + 2));
            if (p == 2) hold_off_req = 1'b1;
            sent = 0;
            while (sent < PHASE_BYTES) begin
                send_random_string(n);
                sent += n;
            end
            wait_idle();
        end

        if (board.fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : watchdog_proc
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/uqpd_pkg.sv
rtl/url_query_percent_decoder.sv
dv/url_query_percent_decoder_tb.sv
